// ===== hdl/ppt_pkg.sv =====
// ppt_pkg: types and codes shared by the point-in-polygon test core and its cells
// no dependencies
`default_nettype none

package ppt_pkg;

	// func field codes of an input beat
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// control part of the token that walks the cell chain
	typedef struct packed {
		logic valid;   // token holds a query
		logic parity;  // crossing parity so far
		logic cand;    // pending edge may cross, products follow the token
		logic dz_pos;  // pending edge has positive z difference
	} tok_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ppt_cell.sv =====
// ppt_cell: one corner register and one edge test stage of the chain
// depends on ppt_pkg (tok_ctl_t)
`default_nettype none

module ppt_cell
	import ppt_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic signed [COORD_BITS-1:0]  wr_x,
	input  wire logic signed [COORD_BITS-1:0]  wr_z,
	input  wire logic                          active,
	input  wire logic                          head,
	input  wire logic                          use_first,
	input  wire tok_ctl_t                      ctl_i,
	input  wire logic signed [COORD_BITS-1:0]  qx_i,
	input  wire logic signed [COORD_BITS-1:0]  qz_i,
	input  wire logic signed [COORD_BITS-1:0]  px_i,
	input  wire logic signed [COORD_BITS-1:0]  pz_i,
	input  wire logic signed [COORD_BITS-1:0]  fx_i,
	input  wire logic signed [COORD_BITS-1:0]  fz_i,
	input  wire logic signed [2*COORD_BITS+1:0] lhs_i,
	input  wire logic signed [2*COORD_BITS+1:0] rhs_i,
	output tok_ctl_t                           ctl_o,
	output logic signed [COORD_BITS-1:0]       qx_o,
	output logic signed [COORD_BITS-1:0]       qz_o,
	output logic signed [COORD_BITS-1:0]       px_o,
	output logic signed [COORD_BITS-1:0]       pz_o,
	output logic signed [COORD_BITS-1:0]       fx_o,
	output logic signed [COORD_BITS-1:0]       fz_o,
	output logic signed [2*COORD_BITS+1:0]     lhs_o,
	output logic signed [2*COORD_BITS+1:0]     rhs_o
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;

	logic signed [CW-1:0] cx_q, cz_q;
	logic signed [CW-1:0] ox, oz;
	logic signed [DW-1:0] dqz, dqx, dpx, dpz;
	logic signed [PW-1:0] lhs_d, rhs_d;
	logic                 straddle, near, edge_en, left_in;
	tok_ctl_t             ctl_q;
	logic signed [CW-1:0] qx_q, qz_q, px_q, pz_q, fx_q, fz_q;
	logic signed [PW-1:0] lhs_q, rhs_q;

	// stored corner
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cx_q <= wr_x;
			cz_q <= wr_z;
		end
	end

	// corner i of this edge: own entry, or the first corner for the closing edge
	assign ox = use_first ? fx_i : cx_q;
	assign oz = use_first ? fz_i : cz_q;

	assign dqz = {qz_i[CW-1], qz_i} - {oz[CW-1], oz};
	assign dqx = {qx_i[CW-1], qx_i} - {ox[CW-1], ox};
	assign dpx = {px_i[CW-1], px_i} - {ox[CW-1], ox};
	assign dpz = {pz_i[CW-1], pz_i} - {oz[CW-1], oz};

	assign lhs_d = dqz * dpx;
	assign rhs_d = dqx * dpz;

	assign straddle = ((oz < qz_i) && (pz_i >= qz_i)) || ((pz_i < qz_i) && (oz >= qz_i));
	assign near     = (ox <= qx_i) || (px_i <= qx_i);
	assign edge_en  = ctl_i.valid && active && !head;

	// resolve the edge handed over by the neighbor
	assign left_in = ctl_i.dz_pos ? (lhs_i < rhs_i) : (rhs_i < lhs_i);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid  <= ctl_i.valid;
			ctl_q.parity <= ctl_i.parity ^ (ctl_i.cand & left_in);
			ctl_q.cand   <= edge_en & straddle & near;
			ctl_q.dz_pos <= dpz > 0;
		end
	end

	always_ff @(posedge clk) begin
		qx_q  <= qx_i;
		qz_q  <= qz_i;
		px_q  <= active ? ox : px_i;
		pz_q  <= active ? oz : pz_i;
		fx_q  <= (active && head) ? ox : fx_i;
		fz_q  <= (active && head) ? oz : fz_i;
		lhs_q <= lhs_d;
		rhs_q <= rhs_d;
	end

	assign ctl_o = ctl_q;
	assign qx_o  = qx_q;
	assign qz_o  = qz_q;
	assign px_o  = px_q;
	assign pz_o  = pz_q;
	assign fx_o  = fx_q;
	assign fz_o  = fz_q;
	assign lhs_o = lhs_q;
	assign rhs_o = rhs_q;

endmodule

`default_nettype wire

// ===== hdl/point_in_polygon_test_core.sv =====
// point_in_polygon_test_core: crossing parity test over a chain of corner cells
// depends on ppt_pkg and ppt_cell
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-----------------------------------
// in      | input     | in_valid / in_ready  | func, corner_index, coord_x, coord_z
// out     | output    | out_valid / out_ready| inside_res
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (corner count)
//
// a load beat writes the corner register of one cell
// a query beat launches a token that moves one cell per cycle through
// MAX_CORNERS corner cells, one closing-edge cell and one drain cell; its
// result is written to the output register, or to the skid slot, as the
// token leaves the drain cell, and no further beat is taken until then
// reset clears the corner count, the token valid bits and the output slots;
// corner registers hold nothing defined until loaded
// a result not taken parks in a skid slot; input stalls while the skid is full
// a count write waits while a query is in flight and holds off the input beat
`default_nettype none

module point_in_polygon_test_core
	import ppt_pkg::*;
#(
	parameter int MAX_CORNERS = 64,
	parameter int COORD_BITS  = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// item channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic [5:0]                   corner_index,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_z,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              inside_res,
	// corner count register
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [6:0]                   cfg_data
);

	localparam int CW    = COORD_BITS;
	localparam int PW    = 2 * (CW + 1);
	localparam int NCELL = MAX_CORNERS + 2;   // corner cells, closing edge, drain

	logic [6:0]  corner_count_q;
	logic        busy_q;
	logic        out_valid_q, res_q;
	logic        skid_valid_q, skid_res_q;
	tok_ctl_t    launch_ctl_q;
	logic signed [CW-1:0] launch_x_q, launch_z_q;

	logic        in_fire, load_fire, query_fire, out_take, done;

	// token chain: index k feeds cell k, cell k drives index k+1
	tok_ctl_t             ctl_c [0:NCELL];
	logic signed [CW-1:0] qx_c  [0:NCELL];
	logic signed [CW-1:0] qz_c  [0:NCELL];
	logic signed [CW-1:0] px_c  [0:NCELL];
	logic signed [CW-1:0] pz_c  [0:NCELL];
	logic signed [CW-1:0] fx_c  [0:NCELL];
	logic signed [CW-1:0] fz_c  [0:NCELL];
	logic signed [PW-1:0] lhs_c [0:NCELL];
	logic signed [PW-1:0] rhs_c [0:NCELL];

	logic [NCELL-1:0] wr_en, act, head, use_first;
	logic [NCELL:0]   tok_valid;

	// a pending count write goes first so it never shares an edge with a beat
	assign in_ready   = !busy_q && !skid_valid_q && !cfg_valid;
	assign in_fire    = in_valid && in_ready;
	assign load_fire  = in_fire && (func == FUNC_LOAD);
	assign query_fire = in_fire && (func == FUNC_QUERY);
	assign cfg_ready  = !busy_q;
	assign out_take   = out_valid_q && out_ready;
	assign done       = ctl_c[NCELL].valid;

	// corner count, written only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			corner_count_q <= cfg_data;
		end
	end

	// one query in flight; busy until its token leaves the drain cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			launch_ctl_q <= '0;
		end else begin
			if (query_fire) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			launch_ctl_q <= tok_ctl_t'{valid: query_fire, parity: 1'b0,
				cand: 1'b0, dz_pos: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			launch_x_q <= coord_x;
			launch_z_q <= coord_z;
		end
	end

	// chain head: the point enters, no corner or pending edge yet
	assign ctl_c[0] = launch_ctl_q;
	assign qx_c[0]  = launch_x_q;
	assign qz_c[0]  = launch_z_q;
	assign px_c[0]  = '0;
	assign pz_c[0]  = '0;
	assign fx_c[0]  = '0;
	assign fz_c[0]  = '0;
	assign lhs_c[0] = '0;
	assign rhs_c[0] = '0;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k < MAX_CORNERS) begin : g_row
			// corner cell: edge from corner k to corner k-1, cell 0 records the first
			assign wr_en[k]     = load_fire && (32'(corner_index) == k);
			assign act[k]       = 32'(corner_count_q) > k;
			assign head[k]      = (k == 0);
			assign use_first[k] = 1'b0;
		end else if (k == MAX_CORNERS) begin : g_close
			// closing edge: first corner against the last active one
			assign wr_en[k]     = 1'b0;
			assign act[k]       = corner_count_q != '0;
			assign head[k]      = 1'b0;
			assign use_first[k] = 1'b1;
		end else begin : g_drain
			// drain: only settles the edge left pending by the closing cell
			assign wr_en[k]     = 1'b0;
			assign act[k]       = 1'b0;
			assign head[k]      = 1'b0;
			assign use_first[k] = 1'b0;
		end

		ppt_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en[k]),
			.wr_x     (coord_x),
			.wr_z     (coord_z),
			.active   (act[k]),
			.head     (head[k]),
			.use_first(use_first[k]),
			.ctl_i    (ctl_c[k]),
			.qx_i     (qx_c[k]),
			.qz_i     (qz_c[k]),
			.px_i     (px_c[k]),
			.pz_i     (pz_c[k]),
			.fx_i     (fx_c[k]),
			.fz_i     (fz_c[k]),
			.lhs_i    (lhs_c[k]),
			.rhs_i    (rhs_c[k]),
			.ctl_o    (ctl_c[k+1]),
			.qx_o     (qx_c[k+1]),
			.qz_o     (qz_c[k+1]),
			.px_o     (px_c[k+1]),
			.pz_o     (pz_c[k+1]),
			.fx_o     (fx_c[k+1]),
			.fz_o     (fz_c[k+1]),
			.lhs_o    (lhs_c[k+1]),
			.rhs_o    (rhs_c[k+1])
		);
	end

	for (genvar k = 0; k <= NCELL; k++) begin : g_tv
		assign tok_valid[k] = ctl_c[k].valid;
	end

	// output register with a skid slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= done;
			end
		end else if (done) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			res_q <= skid_valid_q ? skid_res_q : ctl_c[NCELL].parity;
		end else if (done) begin
			skid_res_q <= ctl_c[NCELL].parity;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = res_q;

`ifndef ASSERT_OFF
	// a query beat always leaves the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_fire |=> busy_q)
		else $error("query accepted but block not busy");

	// a token only leaves the chain while a query is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("result without query in flight");

	// at most one token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one token in the chain");

	// skid only fills behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot full while output register empty");

	// the corner count never changes under a walking token
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !busy_q && !in_fire)
		else $error("corner count written while a query is in flight");
`endif

endmodule

`default_nettype wire
